/* rtl/rau_pkg.sv */
// Shared types, codes and widths of the rational arithmetic unit.
package rau_pkg;

    localparam int OPW = 32;   // operand and result field width
    localparam int WW  = 64;   // wide magnitude width for cross products

    localparam logic [3:0] KIND_REDUCE = 4'd0;
    localparam logic [3:0] KIND_ADD    = 4'd1;
    localparam logic [3:0] KIND_SUB    = 4'd2;
    localparam logic [3:0] KIND_MUL    = 4'd3;
    localparam logic [3:0] KIND_DIV    = 4'd4;
    localparam logic [3:0] KIND_MOD    = 4'd5;
    localparam logic [3:0] KIND_LCM    = 4'd6;
    localparam logic [3:0] KIND_EQ     = 4'd7;
    localparam logic [3:0] KIND_NE     = 4'd8;
    localparam logic [3:0] KIND_LT     = 4'd9;
    localparam logic [3:0] KIND_GT     = 4'd10;
    localparam logic [3:0] KIND_LE     = 4'd11;
    localparam logic [3:0] KIND_GE     = 4'd12;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_DIV = 2'd1,
        ALU_GCD = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    half;   // multiplier operand fits the low half
    } alu_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

endpackage

/* rtl/rau_alu.sv */
// Shared iterative unit: shift-add multiply, restoring divide, binary gcd.
module rau_alu import rau_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  alu_cmd_t      cmd,
    input  logic [WW-1:0] opa,
    input  logic [WW-1:0] opb,
    output alu_rsp_t      rsp,
    output logic [WW-1:0] res_q,
    output logic [WW-1:0] res_r
);

    logic          busy_reg;
    logic          done_reg;
    logic          ovf_reg;
    alu_op_t       op_reg;
    logic [6:0]    cnt_reg;
    logic [5:0]    k_reg;
    logic [WW-1:0] acc_reg;
    logic [WW-1:0] ra_reg;
    logic [WW-1:0] rb_reg;

    logic          last;
    logic [WW:0]   mul_sum;
    logic [WW:0]   div_trial;
    logic          div_ge;
    logic [WW:0]   div_diff;

    always_comb begin
        mul_sum   = {1'b0, acc_reg[WW-2:0], 1'b0} + {1'b0, (rb_reg[WW-1] ? ra_reg : '0)};
        div_trial = {acc_reg, ra_reg[WW-1]};
        div_ge    = div_trial >= {1'b0, rb_reg};
        div_diff  = div_trial - {1'b0, rb_reg};
        unique case (op_reg)
            ALU_GCD: last = (ra_reg == '0) || (rb_reg == '0);
            default: last = (cnt_reg == 7'd1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= cmd.op;
            ovf_reg <= 1'b0;
            k_reg   <= '0;
            acc_reg <= '0;
            ra_reg  <= opa;
            cnt_reg <= (cmd.op == ALU_MUL && cmd.half) ? 7'd32 : 7'd64;
            rb_reg  <= (cmd.op == ALU_MUL && cmd.half) ? {opb[WW/2-1:0], {(WW/2){1'b0}}} : opb;
        end else if (busy_reg) begin
            unique case (op_reg)
                ALU_MUL: begin
                    ovf_reg <= ovf_reg | acc_reg[WW-1] | mul_sum[WW];
                    acc_reg <= mul_sum[WW-1:0];
                    rb_reg  <= {rb_reg[WW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                ALU_DIV: begin
                    acc_reg <= div_ge ? div_diff[WW-1:0] : div_trial[WW-1:0];
                    ra_reg  <= {ra_reg[WW-2:0], div_ge};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                ALU_GCD: begin
                    priority if (ra_reg == '0) begin
                        acc_reg <= rb_reg << k_reg;
                    end else if (rb_reg == '0) begin
                        acc_reg <= ra_reg << k_reg;
                    end else if (!ra_reg[0] && !rb_reg[0]) begin
                        ra_reg <= ra_reg >> 1;
                        rb_reg <= rb_reg >> 1;
                        k_reg  <= k_reg + 6'd1;
                    end else if (!ra_reg[0]) begin
                        ra_reg <= ra_reg >> 1;
                    end else if (!rb_reg[0]) begin
                        rb_reg <= rb_reg >> 1;
                    end else if (ra_reg >= rb_reg) begin
                        ra_reg <= ra_reg - rb_reg;
                    end else begin
                        rb_reg <= rb_reg - ra_reg;
                    end
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign res_q    = (op_reg == ALU_DIV) ? ra_reg : acc_reg;
    assign res_r    = acc_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg) else $error("command issued while unit busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done raised while still busy");
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (op_reg == ALU_MUL || op_reg == ALU_DIV) |-> cnt_reg != 7'd0)
        else $error("iteration count ran out while busy");

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Every item first forms the three cross products on the shared unit; lcm then runs binary gcd
// passes and divides on the same unit and ends with a full-width multiply.
// One item at a time; the next beat is taken once the result is in the output register.
// The shared iterative unit does one multiply, divide or gcd step per cycle while busy.
// Reset: synchronous active-low aresetn clears the sequencer, the unit and the output valid.
// No stored state survives an item; there is no clearing pass.
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_kind,
    input  logic signed [OPW-1:0] s_a_num,
    input  logic signed [OPW-1:0] s_a_den,
    input  logic signed [OPW-1:0] s_b_num,
    input  logic signed [OPW-1:0] s_b_den,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [OPW-1:0] m_res_num,
    output logic signed [OPW-1:0] m_res_den,
    output logic                  m_truth,
    output logic [1:0]            m_status
);

    // One-hot sequencer states
    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_MAN  = 19'h00002,  // |a_num| * |b_den|
        S_MBN  = 19'h00004,  // |b_num| * |a_den|
        S_MD   = 19'h00008,  // |a_den| * |b_den|
        S_DISP = 19'h00010,  // pick the path for this kind
        S_AUX  = 19'h00020,  // kind specific extra product or remainder
        S_GCD  = 19'h00040,
        S_DN   = 19'h00080,
        S_DD   = 19'h00100,
        S_LG0  = 19'h00200,
        S_LQ   = 19'h00400,
        S_LG1  = 19'h00800,
        S_LQ2  = 19'h01000,
        S_LD1  = 19'h02000,
        S_LG2  = 19'h04000,
        S_LN2  = 19'h08000,
        S_LD2  = 19'h10000,
        S_LMUL = 19'h20000,
        S_FIN  = 19'h40000
    } state_t;

    state_t state_reg;
    logic   wait_reg;

    // Latched operands as sign and magnitude
    logic [3:0]     kind_reg;
    logic           as_reg, ads_reg, bs_reg, bds_reg;
    logic [OPW-1:0] am_reg, adm_reg, bm_reg, bdm_reg;

    // Cross products and the working fraction
    logic [WW-1:0]  an_reg, bn_reg, dm_reg, g_reg;
    logic           ans_reg, bns_reg, ds_reg;
    logic [WW-1:0]  nmag_reg, dmag_reg;
    logic           nneg_reg, dneg_reg;
    logic [1:0]     st_reg;
    logic           truth_reg;

    // Output register
    logic                  m_valid_reg;
    logic signed [OPW-1:0] m_num_reg, m_den_reg;
    logic                  m_truth_reg;
    logic [1:0]            m_status_reg;

    // Shared unit
    alu_cmd_t      cmd;
    alu_rsp_t      rsp;
    logic [WW-1:0] opa, opb, res_q, res_r;

    rau_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .rsp     (rsp),
        .res_q   (res_q),
        .res_r   (res_r)
    );

    logic accept;
    logic alu_state;
    logic zero_den;
    logic signed [WW:0] an_sv, bn_sv;
    logic           y_neg;
    logic [WW:0]    add_sum;
    logic           add_neg;
    logic [WW-1:0]  add_mag;
    logic           fin_go;
    logic           n_fits, d_fits;
    logic [WW-1:0]  n_raw, d_raw;
    logic [WW-1:0]  half_mag;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign zero_den = (adm_reg == '0) || (bdm_reg == '0);

    assign alu_state = (state_reg != S_IDLE) && (state_reg != S_DISP) && (state_reg != S_FIN);

    // Operand selection for the shared unit
    always_comb begin
        cmd.start = alu_state && !wait_reg;
        cmd.op    = ALU_MUL;
        cmd.half  = 1'b1;
        opa       = '0;
        opb       = '0;
        unique case (state_reg)
            S_MAN: begin
                opa = WW'(am_reg);  opb = WW'(bdm_reg);
            end
            S_MBN: begin
                opa = WW'(bm_reg);  opb = WW'(adm_reg);
            end
            S_MD: begin
                opa = WW'(adm_reg); opb = WW'(bdm_reg);
            end
            S_AUX: begin
                priority case (kind_reg)
                    KIND_MUL: begin
                        opa = WW'(am_reg);  opb = WW'(bm_reg);
                    end
                    KIND_DIV: begin
                        opa = WW'(adm_reg); opb = WW'(bm_reg);
                    end
                    default: begin
                        cmd.op = ALU_DIV; opa = an_reg; opb = bn_reg;
                    end
                endcase
            end
            S_GCD: begin
                cmd.op = ALU_GCD; opa = nmag_reg; opb = dmag_reg;
            end
            S_DN: begin
                cmd.op = ALU_DIV; opa = nmag_reg; opb = g_reg;
            end
            S_DD, S_LD1, S_LD2: begin
                cmd.op = ALU_DIV; opa = dmag_reg; opb = g_reg;
            end
            S_LG0: begin
                cmd.op = ALU_GCD; opa = an_reg; opb = bn_reg;
            end
            S_LQ, S_LQ2: begin
                cmd.op = ALU_DIV; opa = an_reg; opb = g_reg;
            end
            S_LG1: begin
                cmd.op = ALU_GCD; opa = an_reg; opb = dmag_reg;
            end
            S_LG2: begin
                cmd.op = ALU_GCD; opa = bn_reg; opb = dmag_reg;
            end
            S_LN2: begin
                cmd.op = ALU_DIV; opa = bn_reg; opb = g_reg;
            end
            S_LMUL: begin
                cmd.half = 1'b0; opa = an_reg; opb = bn_reg;
            end
            default: begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // Signed cross products for comparisons, sign-magnitude add for add/sub
    always_comb begin
        an_sv   = ans_reg ? -$signed({1'b0, an_reg}) : $signed({1'b0, an_reg});
        bn_sv   = bns_reg ? -$signed({1'b0, bn_reg}) : $signed({1'b0, bn_reg});
        y_neg   = bns_reg ^ (kind_reg == KIND_SUB);
        add_sum = {1'b0, an_reg} + {1'b0, bn_reg};
        if (ans_reg == y_neg) begin
            add_neg = ans_reg;
            add_mag = add_sum[WW-1:0];
        end else if (an_reg >= bn_reg) begin
            add_neg = ans_reg;
            add_mag = an_reg - bn_reg;
        end else begin
            add_neg = y_neg;
            add_mag = bn_reg - an_reg;
        end
    end

    // Range check and truncation to the field width
    always_comb begin
        half_mag = WW'(1) << (OPW - 1);
        n_fits   = nneg_reg ? (nmag_reg <= half_mag) : (nmag_reg < half_mag);
        d_fits   = dneg_reg ? (dmag_reg <= half_mag) : (dmag_reg < half_mag);
        n_raw    = nneg_reg ? (~nmag_reg + WW'(1)) : nmag_reg;
        d_raw    = dneg_reg ? (~dmag_reg + WW'(1)) : dmag_reg;
    end

    assign fin_go = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // Sequencer: each unit state issues once, then waits for done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                wait_reg <= 1'b1;
            end else if (rsp.done) begin
                wait_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (accept) state_reg <= S_MAN;
                S_MAN:  if (rsp.done) state_reg <= S_MBN;
                S_MBN:  if (rsp.done) state_reg <= S_MD;
                S_MD:   if (rsp.done) state_reg <= S_DISP;
                S_DISP: begin
                    priority if (kind_reg == KIND_REDUCE) begin
                        state_reg <= S_GCD;
                    end else if (kind_reg >= KIND_ADD && kind_reg <= KIND_LCM && zero_den) begin
                        state_reg <= S_FIN;
                    end else if (kind_reg == KIND_ADD || kind_reg == KIND_SUB) begin
                        state_reg <= S_GCD;
                    end else if (kind_reg == KIND_MUL || kind_reg == KIND_DIV) begin
                        state_reg <= S_AUX;
                    end else if (kind_reg == KIND_MOD) begin
                        state_reg <= (bn_reg == '0) ? S_FIN : S_AUX;
                    end else if (kind_reg == KIND_LCM) begin
                        state_reg <= (an_reg == '0 || bn_reg == '0) ? S_GCD : S_LG0;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_AUX:  if (rsp.done) state_reg <= S_GCD;
                S_GCD:  if (rsp.done) state_reg <= (res_q == '0) ? S_FIN : S_DN;
                S_DN:   if (rsp.done) state_reg <= S_DD;
                S_DD:   if (rsp.done) state_reg <= S_FIN;
                S_LG0:  if (rsp.done) state_reg <= S_LQ;
                S_LQ:   if (rsp.done) state_reg <= S_LG1;
                S_LG1:  if (rsp.done) state_reg <= S_LQ2;
                S_LQ2:  if (rsp.done) state_reg <= S_LD1;
                S_LD1:  if (rsp.done) state_reg <= S_LG2;
                S_LG2:  if (rsp.done) state_reg <= S_LN2;
                S_LN2:  if (rsp.done) state_reg <= S_LD2;
                S_LD2:  if (rsp.done) state_reg <= S_LMUL;
                S_LMUL: if (rsp.done) state_reg <= S_FIN;
                S_FIN:  if (fin_go) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            as_reg   <= s_a_num[OPW-1];
            ads_reg  <= s_a_den[OPW-1];
            bs_reg   <= s_b_num[OPW-1];
            bds_reg  <= s_b_den[OPW-1];
            am_reg   <= s_a_num[OPW-1] ? -s_a_num : s_a_num;
            adm_reg  <= s_a_den[OPW-1] ? -s_a_den : s_a_den;
            bm_reg   <= s_b_num[OPW-1] ? -s_b_num : s_b_num;
            bdm_reg  <= s_b_den[OPW-1] ? -s_b_den : s_b_den;
        end
        if (rsp.done) begin
            unique case (state_reg)
                S_MAN: begin
                    an_reg  <= res_q; ans_reg <= as_reg ^ bds_reg;
                end
                S_MBN: begin
                    bn_reg  <= res_q; bns_reg <= bs_reg ^ ads_reg;
                end
                S_MD: begin
                    dm_reg  <= res_q; ds_reg  <= ads_reg ^ bds_reg;
                end
                S_AUX: begin
                    priority case (kind_reg)
                        KIND_MUL: nmag_reg <= res_q;
                        KIND_DIV: dmag_reg <= res_q;
                        default:  nmag_reg <= res_r;
                    endcase
                end
                S_GCD, S_LG0, S_LG1, S_LG2: g_reg <= res_q;
                S_DN:           nmag_reg <= res_q;
                S_DD, S_LD1, S_LD2: dmag_reg <= res_q;
                S_LQ, S_LQ2:    an_reg   <= res_q;
                S_LN2:          bn_reg   <= res_q;
                S_LMUL: begin
                    nmag_reg <= res_q;
                    nneg_reg <= 1'b0;
                    st_reg   <= rsp.ovf ? ST_OVF : ST_OK;
                end
                default: g_reg <= g_reg;
            endcase
        end
        if (state_reg == S_DISP) begin
            // By default the working fraction is the left cross product over the common denominator
            nmag_reg  <= an_reg;
            nneg_reg  <= ans_reg;
            dmag_reg  <= dm_reg;
            dneg_reg  <= ds_reg;
            st_reg    <= ST_OK;
            truth_reg <= 1'b0;
            priority if (kind_reg == KIND_REDUCE ||
                         (kind_reg >= KIND_ADD && kind_reg <= KIND_LCM && zero_den) ||
                         (kind_reg == KIND_MOD && bn_reg == '0)) begin
                nmag_reg <= WW'(am_reg);
                nneg_reg <= as_reg;
                dmag_reg <= WW'(adm_reg);
                dneg_reg <= ads_reg;
                st_reg   <= (kind_reg == KIND_MOD && !zero_den) ? ST_DIV0 : ST_OK;
            end else if (kind_reg == KIND_ADD || kind_reg == KIND_SUB) begin
                nmag_reg <= add_mag;
                nneg_reg <= add_neg;
            end else if (kind_reg == KIND_MUL) begin
                nneg_reg <= as_reg ^ bs_reg;
            end else if (kind_reg == KIND_DIV) begin
                dneg_reg <= ads_reg ^ bs_reg;
                st_reg   <= (bm_reg == '0) ? ST_DIV0 : ST_OK;
            end else if (kind_reg == KIND_MOD || kind_reg == KIND_LCM) begin
                // mod keeps the sign of the left cross product; lcm zero case is 0/d
                if (kind_reg == KIND_LCM) nmag_reg <= '0;
            end else begin
                nmag_reg <= '0;
                dmag_reg <= '0;
                unique case (kind_reg)
                    KIND_EQ: truth_reg <= zero_den ? (am_reg != '0) : (an_sv == bn_sv);
                    KIND_NE: truth_reg <= zero_den ? (am_reg != '0) : (an_sv != bn_sv);
                    KIND_LT: truth_reg <= an_sv <  bn_sv;
                    KIND_GT: truth_reg <= an_sv >  bn_sv;
                    KIND_LE: truth_reg <= an_sv <= bn_sv;
                    KIND_GE: truth_reg <= an_sv >= bn_sv;
                    default: truth_reg <= 1'b0;
                endcase
            end
        end
        if (fin_go) begin
            m_num_reg    <= n_raw[OPW-1:0];
            m_den_reg    <= d_raw[OPW-1:0];
            m_truth_reg  <= truth_reg;
            m_status_reg <= (st_reg == ST_OK && (!n_fits || !d_fits)) ? ST_OVF : st_reg;
        end
    end

    // Output beat: hold until taken, reload from the finish state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_res_num = m_num_reg;
    assign m_res_den = m_den_reg;
    assign m_truth   = m_truth_reg;
    assign m_status  = m_status_reg;

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("sequencer state not one-hot");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready) else $error("input still ready after accepting a beat");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_FIN)) else $error("result loaded outside finish");
    a_done_in_unit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> alu_state && wait_reg) else $error("unit done with no command pending");

endmodule

/* tb/testbench.sv */
// Testbench for the rational arithmetic unit: directed and random fraction pairs, scoreboarded.
module testbench import rau_pkg::*; ();

    // Silence limit: the longest item plus a random output stall, with plenty more allowed.
    localparam int STALL_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct {
        logic signed [OPW-1:0] num;
        logic signed [OPW-1:0] den;
        logic                  truth;
        logic [1:0]            status;
    } fraction_result_t;

    // Sign plus 64-bit magnitude, as the cross products are held.
    typedef struct {
        bit        neg;
        bit [63:0] mag;
    } signed_mag_t;

    // Scoreboard: predicts each accepted beat and checks results in order.
    class fraction_scoreboard;
        fraction_result_t awaited[$];
        int               mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function signed_mag_t split(longint v);
            signed_mag_t r;
            r.neg = v < 0;
            r.mag = v;
            if (r.neg)
                r.mag = -r.mag;
            return r;
        endfunction

        static function signed_mag_t sum(signed_mag_t x, signed_mag_t y);
            signed_mag_t r;
            if (x.neg == y.neg) begin
                r.neg = x.neg;
                r.mag = x.mag + y.mag;
            end else if (x.mag >= y.mag) begin
                r.neg = x.neg;
                r.mag = x.mag - y.mag;
            end else begin
                r.neg = y.neg;
                r.mag = y.mag - x.mag;
            end
            return r;
        endfunction

        static function bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
            bit [63:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        static function bit in_range(signed_mag_t v);
            bit [63:0] half;
            half = 64'd1 << (OPW - 1);
            return v.neg ? (v.mag <= half) : (v.mag < half);
        endfunction

        // Optionally reduce by the gcd, flag overflow, truncate to the field width.
        static function fraction_result_t settle(signed_mag_t n, signed_mag_t d, bit reduce,
                                                 logic [1:0] st);
            fraction_result_t r;
            bit [63:0] g, raw;
            if (reduce) begin
                g = gcd64(n.mag, d.mag);
                if (g != 0) begin
                    n.mag = n.mag / g;
                    d.mag = d.mag / g;
                end
            end
            if (st == ST_OK && (!in_range(n) || !in_range(d)))
                st = ST_OVF;
            raw = n.neg ? -n.mag : n.mag;
            r.num = raw[OPW-1:0];
            raw = d.neg ? -d.mag : d.mag;
            r.den = raw[OPW-1:0];
            r.truth = 1'b0;
            r.status = st;
            return r;
        endfunction

        static function fraction_result_t verdict(bit t);
            fraction_result_t r;
            r.num = '0;
            r.den = '0;
            r.truth = t;
            r.status = ST_OK;
            return r;
        endfunction

        static function fraction_result_t evaluate(logic [3:0] kind,
                                                   logic signed [OPW-1:0] a_num,
                                                   logic signed [OPW-1:0] a_den,
                                                   logic signed [OPW-1:0] b_num,
                                                   logic signed [OPW-1:0] b_den);
            longint an0, ad0, bn0, bd0, cross_a, cross_b, den_prod;
            bit zero_den;
            signed_mag_t x, y, dd;
            bit [63:0] m, n, q, n2, dm, g;
            bit ovf;
            an0 = a_num;
            ad0 = a_den;
            bn0 = b_num;
            bd0 = b_den;
            cross_a = an0 * bd0;
            cross_b = bn0 * ad0;
            den_prod = ad0 * bd0;
            zero_den = (ad0 == 0) || (bd0 == 0);

            if (kind == KIND_REDUCE)
                return settle(split(an0), split(ad0), 1'b1, ST_OK);
            if (kind >= KIND_ADD && kind <= KIND_LCM && zero_den)
                return settle(split(an0), split(ad0), 1'b0, ST_OK);

            case (kind)
                KIND_ADD: return settle(sum(split(cross_a), split(cross_b)), split(den_prod),
                                        1'b1, ST_OK);
                KIND_SUB: begin
                    y = split(cross_b);
                    y.neg = !y.neg;
                    return settle(sum(split(cross_a), y), split(den_prod), 1'b1, ST_OK);
                end
                KIND_MUL: return settle(split(an0 * bn0), split(den_prod), 1'b1, ST_OK);
                KIND_DIV: return settle(split(cross_a), split(ad0 * bn0), 1'b1,
                                        (bn0 == 0) ? ST_DIV0 : ST_OK);
                KIND_MOD: begin
                    if (cross_b == 0)
                        return settle(split(an0), split(ad0), 1'b0, ST_DIV0);
                    x = split(cross_a);
                    y = split(cross_b);
                    x.mag = x.mag % y.mag;
                    return settle(x, split(den_prod), 1'b1, ST_OK);
                end
                KIND_LCM: begin
                    m = split(cross_a).mag;
                    n = split(cross_b).mag;
                    dd = split(den_prod);
                    if (m == 0 || n == 0)
                        return settle(split(0), dd, 1'b1, ST_OK);
                    q = m / gcd64(m, n);
                    dm = dd.mag;
                    g = gcd64(q, dm);
                    q = q / g;
                    dm = dm / g;
                    g = gcd64(n, dm);
                    n2 = n / g;
                    dm = dm / g;
                    ovf = q > ({64{1'b1}} / n2);
                    x.neg = 1'b0;
                    x.mag = q * n2;
                    dd.mag = dm;
                    return settle(x, dd, 1'b0, ovf ? ST_OVF : ST_OK);
                end
                KIND_EQ: return verdict(zero_den ? (an0 != 0) : (cross_a == cross_b));
                KIND_NE: return verdict(zero_den ? (an0 != 0) : (cross_a != cross_b));
                KIND_LT: return verdict(cross_a < cross_b);
                KIND_GT: return verdict(cross_a > cross_b);
                KIND_LE: return verdict(cross_a <= cross_b);
                KIND_GE: return verdict(cross_a >= cross_b);
                default: return verdict(1'b0);
            endcase
        endfunction

        function void note_operands(logic [3:0] kind, logic signed [OPW-1:0] a_num,
                                    logic signed [OPW-1:0] a_den,
                                    logic signed [OPW-1:0] b_num,
                                    logic signed [OPW-1:0] b_den);
            awaited.push_back(evaluate(kind, a_num, a_den, b_num, b_den));
        endfunction

        function void check_result(fraction_result_t got);
            fraction_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: num %0d den %0d truth %0b status %0d",
                             got.num, got.den, got.truth, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.num !== want.num || got.den !== want.den || got.truth !== want.truth ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d truth %0b status %0d, got %0d/%0d truth %0b status %0d",
                             want.num, want.den, want.truth, want.status,
                             got.num, got.den, got.truth, got.status);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [3:0]            s_kind;
    logic signed [OPW-1:0] s_a_num;
    logic signed [OPW-1:0] s_a_den;
    logic signed [OPW-1:0] s_b_num;
    logic signed [OPW-1:0] s_b_den;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [OPW-1:0] m_res_num;
    logic signed [OPW-1:0] m_res_den;
    logic                  m_truth;
    logic [1:0]            m_status;

    fraction_scoreboard sb = new();
    bit calm;          // set for the last part of the run: no idling on either side
    int quiet_cycles;
    int ready_hold;

    rational_arithmetic_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_truth   (m_truth),
        .m_status  (m_status)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: hold ready low for random bursts, otherwise keep it high.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: note every accepted operand beat, check every accepted result beat,
    // and drop the run if the block goes silent for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_operands(s_kind, s_a_num, s_a_den, s_b_num, s_b_den);
            if (m_valid && m_ready)
                sb.check_result('{m_res_num, m_res_den, m_truth, m_status});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Present one operand beat and hold it until the block takes it. A random idle
    // burst may come first; valid then drops for the burst only.
    task automatic send_operands(logic [3:0] kind, logic signed [OPW-1:0] a_num,
                                 logic signed [OPW-1:0] a_den,
                                 logic signed [OPW-1:0] b_num,
                                 logic signed [OPW-1:0] b_den);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_a_num <= a_num;
        s_a_den <= a_den;
        s_b_num <= b_num;
        s_b_den <= b_den;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Operand values: often small so reductions and comparisons are meaningful,
    // with extremes and full-width noise mixed in.
    function automatic logic signed [OPW-1:0] pick_value();
        logic signed [OPW-1:0] v;
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                   0: v = 0;
                   1: v = 1;
                   2: v = -1;
                   3: v = {1'b0, {(OPW-1){1'b1}}};
                   default: v = {1'b1, {(OPW-1){1'b0}}};
               endcase
            1, 2, 3, 4: v = $signed($urandom_range(0, 100)) - 50;
            5, 6: v = $urandom;
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [OPW-1:0] pick_denominator();
        if ($urandom_range(0, 11) == 0)
            return 0;
        return pick_value();
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_operands(4'($urandom_range(0, 15)), pick_value(), pick_denominator(),
                          pick_value(), pick_denominator());
    endtask

    initial begin
        logic signed [OPW-1:0] max_v, min_v;
        max_v = {1'b0, {(OPW-1){1'b1}}};
        min_v = {1'b1, {(OPW-1){1'b0}}};
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_REDUCE;
        s_a_num = '0;
        s_a_den = '0;
        s_b_num = '0;
        s_b_den = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every operation on one ordinary pair, then the unused kinds.
        for (int k = 0; k <= 15; k++)
            send_operands(4'(k), 3, 4, -5, 6);
        // Special cases.
        send_operands(KIND_REDUCE, 0, 0, 1, 1);            // zero over zero
        send_operands(KIND_REDUCE, -7, 0, 1, 1);           // zero denominator
        send_operands(KIND_ADD, 5, 0, 1, 2);               // zero denominator passes left through
        send_operands(KIND_EQ, 2, 3, 4, 0);                // equality with zero denominator
        send_operands(KIND_LT, 1, -2, 1, 3);               // ordering with negative denominator
        send_operands(KIND_DIV, 3, 4, 0, 5);               // divide by zero numerator
        send_operands(KIND_MOD, 3, 4, 0, 5);               // modulo by zero
        send_operands(KIND_MUL, max_v, 1, max_v, 1);       // overflow
        send_operands(KIND_ADD, min_v, 1, min_v, 1);       // extreme sum
        send_operands(KIND_LCM, min_v, max_v, max_v, min_v);

        send_random(500);
        // Hold the sender until every awaited result has come back.
        s_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        send_random(400);
        calm = 1'b1;
        send_random(100);
        s_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
